// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the rtl; clocked, disabled while in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_ON_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// condition in one cycle implies consequence in the next
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/smx_pkg.sv =====
// ----------------------------------------------------------------------------
// smx_pkg
// Types, opcodes, error codes and opcode tables of the stack machine core
// ----------------------------------------------------------------------------
package smx_pkg;

    localparam int ADDR_W = 13;
    localparam int CFG_W  = 13;

    // opcodes
    localparam logic [4:0] OP_PUSHI = 5'd0;
    localparam logic [4:0] OP_POP   = 5'd1;
    localparam logic [4:0] OP_ADD   = 5'd2;
    localparam logic [4:0] OP_SUB   = 5'd3;
    localparam logic [4:0] OP_MUL   = 5'd4;
    localparam logic [4:0] OP_DIV   = 5'd5;
    localparam logic [4:0] OP_MOD   = 5'd6;
    localparam logic [4:0] OP_NEG   = 5'd7;
    localparam logic [4:0] OP_EQ    = 5'd8;
    localparam logic [4:0] OP_NEQ   = 5'd9;
    localparam logic [4:0] OP_LT    = 5'd10;
    localparam logic [4:0] OP_GT    = 5'd11;
    localparam logic [4:0] OP_LTE   = 5'd12;
    localparam logic [4:0] OP_GTE   = 5'd13;
    localparam logic [4:0] OP_AND   = 5'd14;
    localparam logic [4:0] OP_OR    = 5'd15;
    localparam logic [4:0] OP_NOT   = 5'd16;
    localparam logic [4:0] OP_LOAD  = 5'd17;
    localparam logic [4:0] OP_PUT   = 5'd18;
    localparam logic [4:0] OP_JMP   = 5'd19;
    localparam logic [4:0] OP_JZ    = 5'd20;
    localparam logic [4:0] OP_CALL  = 5'd21;
    localparam logic [4:0] OP_RET   = 5'd22;
    localparam logic [4:0] OP_ALLOC = 5'd23;
    localparam logic [4:0] OP_EMIT  = 5'd24;
    localparam logic [4:0] OP_SCAN  = 5'd25;
    localparam logic [4:0] OP_HALT  = 5'd26;

    // error codes
    localparam logic [3:0] ERR_NONE    = 4'd0;
    localparam logic [3:0] ERR_ADDR    = 4'd1;
    localparam logic [3:0] ERR_DIVZ    = 4'd2;
    localparam logic [3:0] ERR_MODZ    = 4'd3;
    localparam logic [3:0] ERR_CALLOV  = 4'd4;
    localparam logic [3:0] ERR_NOFRAME = 4'd5;
    localparam logic [3:0] ERR_UNKNOWN = 4'd6;
    localparam logic [3:0] ERR_UNDER   = 4'd7;
    localparam logic [3:0] ERR_OVER    = 4'd8;
    localparam logic [3:0] ERR_SLOT    = 4'd9;

    typedef struct packed {
        logic [4:0]         func;
        logic signed [31:0] imm_first;
        logic [8:0]         imm_second;
        logic signed [31:0] scan_value;
    } t_in;

    typedef struct packed {
        logic [11:0]        next_address;
        logic               print_valid;
        logic signed [31:0] print_value;
        logic               halted;
        logic signed [31:0] halt_value;
        logic [3:0]         error_code;
    } t_out;

    // stack read address select
    typedef enum logic [1:0] {
        RD_TOP  = 2'd0,
        RD_NEXT = 2'd1,
        RD_SLOT = 2'd2
    } t_rd_sel;

    typedef struct packed {
        logic    latch;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    cap_b;
        logic    cap_a;
        logic    div_start;
        logic    div_step;
        logic    commit;
        logic    fill_step;
        logic    load_out;
    } t_cmd;

    typedef struct packed {
        logic stopped;
        logic div_go;
        logic div_done;
        logic fill_go;
        logic fill_done;
        logic out_busy;
    } t_stat;

    // operands taken from the stack
    function automatic logic [1:0] op_pops(input logic [4:0] op);
        logic [1:0] n;
        n = 2'd0;
        unique case (op) inside
            [OP_ADD:OP_MOD], [OP_EQ:OP_OR]:                   n = 2'd2;
            OP_POP, OP_NEG, OP_NOT, OP_PUT, OP_JZ, OP_RET,
            OP_EMIT:                                           n = 2'd1;
            default:                                           n = 2'd0;
        endcase
        return n;
    endfunction

    // one result pushed
    function automatic logic op_push(input logic [4:0] op);
        logic p;
        p = 1'b0;
        unique case (op) inside
            [OP_PUSHI:OP_PUSHI], [OP_ADD:OP_LOAD], OP_EMIT, OP_SCAN: p = 1'b1;
            default:                                                  p = 1'b0;
        endcase
        return p;
    endfunction

    // instruction length in code words
    function automatic logic [1:0] op_len(input logic [4:0] op);
        logic [1:0] n;
        n = 2'd1;
        unique case (op) inside
            OP_PUSHI, OP_LOAD, OP_PUT, OP_JMP, OP_JZ, OP_ALLOC: n = 2'd2;
            OP_CALL:                                             n = 2'd3;
            default:                                             n = 2'd1;
        endcase
        return n;
    endfunction

endpackage

// ===== hw/rtl/stack_machine_execute_core.sv =====
// ----------------------------------------------------------------------------
// stack_machine_execute_core
// Execution core of a 32-bit stack machine with call frames
// ----------------------------------------------------------------------------
// One decoded instruction is taken per item and answered with one result
// item. A plain instruction passes the check, two read, execute and done
// states before its result is loaded into the output register, and only
// then is the next item accepted; the operand stack has a single registered
// read port, so the two operands and the load slot are fetched one after
// another. div and mod pass through the bit-serial divider state before the
// commit, and alloc adds a fill state that zeroes one local per step, since
// the locals are zeroed through the single stack write port.
// An output register lets a new item in while a result still waits.
// ----------------------------------------------------------------------------
module stack_machine_execute_core #(
    parameter int STACK_DEPTH = 256,
    parameter int FRAME_DEPTH = 64,
    parameter int CODE_WORDS  = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  smx_pkg::t_in              i_item,
    output logic                      o_valid,
    input  logic                      i_stall,
    output smx_pkg::t_out             o_item,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [smx_pkg::CFG_W-1:0] i_cfg_data
);
    import smx_pkg::*;

`include "assert_macros.svh"

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_err_ok;

    assign o_cfg_ready = 1'b1;

    // sequencer
    smx_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // datapath
    smx_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .FRAME_DEPTH (FRAME_DEPTH),
        .CODE_WORDS  (CODE_WORDS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_item      (i_item),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_item      (o_item)
    );

    // an error code only ever comes with the halted flag
    assign w_err_ok = (o_item.error_code == ERR_NONE) || o_item.halted;

    // checks
    `ASSERT_NEXT(a_stop_sticky, i_clk, i_rst_n, w_stat.stopped, w_stat.stopped)
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    `ASSERT_ON_CLK(a_err_halts, i_clk, i_rst_n, o_valid |-> w_err_ok)

endmodule

// ===== hw/rtl/smx_ctrl.sv =====
// ----------------------------------------------------------------------------
// smx_ctrl
// Sequencer of the stack machine: operand fetch, divide, commit, local fill
// ----------------------------------------------------------------------------
module smx_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  smx_pkg::t_stat i_stat,
    output smx_pkg::t_cmd  o_cmd
);
    import smx_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_RDA   = 8'b0000_0100,
        S_RDX   = 8'b0000_1000,
        S_EXEC  = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_FILL  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_TOP;
                n_state      = S_RDA;
            end
            S_RDA: begin
                o_cmd.cap_b  = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_NEXT;
                n_state      = S_RDX;
            end
            S_RDX: begin
                o_cmd.cap_a  = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_SLOT;
                n_state      = S_EXEC;
            end
            S_EXEC: begin
                if (i_stat.div_go) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end else begin
                    o_cmd.commit = 1'b1;
                    n_state      = i_stat.fill_go ? S_FILL : S_DONE;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_FILL: begin
                if (i_stat.fill_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.fill_step = 1'b1;
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/smx_datapath.sv =====
// ----------------------------------------------------------------------------
// smx_datapath
// Operand stack, frame stack, machine registers, checks, alu, divider and
// the output register of the stack machine
// ----------------------------------------------------------------------------
module smx_datapath #(
    parameter int STACK_DEPTH = 256,
    parameter int FRAME_DEPTH = 64,
    parameter int CODE_WORDS  = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [smx_pkg::CFG_W-1:0]  i_cfg_data,
    input  smx_pkg::t_in               i_item,
    input  smx_pkg::t_cmd              i_cmd,
    output smx_pkg::t_stat             o_stat,
    input  logic                       i_stall,
    output logic                       o_valid,
    output smx_pkg::t_out              o_item
);
    import smx_pkg::*;

    localparam int SPW = $clog2(STACK_DEPTH);
    localparam int FAW = $clog2(FRAME_DEPTH);
    localparam int FCW = $clog2(FRAME_DEPTH + 1);
    localparam int AW  = ADDR_W;
    localparam int RAW = ADDR_W + 1;
    localparam int FW  = RAW + SPW;
    localparam logic [AW-1:0] LEN_CAP = (CODE_WORDS < 8191) ? AW'(CODE_WORDS) : AW'(8191);

    // machine state
    logic [SPW-1:0] r_sp, r_fb, r_fill;
    logic [AW-1:0]  r_ia, r_plen;
    logic [FCW-1:0] r_fc;
    logic           r_stopped;
    logic [3:0]     r_err;
    logic [31:0]    r_halt;
    logic           r_ovalid;

    // payload registers
    t_in            r_in;
    logic [31:0]    r_a, r_b, r_rd;
    logic [FW-1:0]  r_frd;
    logic           r_pv;
    logic [31:0]    r_pval;
    t_out           r_out;
    logic [31:0]    r_dq, r_dd;
    logic [32:0]    r_rem;
    logic [5:0]     r_dcnt;

    // memories
    logic [31:0]    r_stack [STACK_DEPTH];
    logic [FW-1:0]  r_frame [FRAME_DEPTH];

    logic [4:0]        op;
    logic [1:0]        pops, olen;
    logic              push;
    logic [AW-1:0]     len;
    logic signed [33:0] imm_x, idx, sp_s, nxt, ia_x;
    logic [30:0]       nl;
    logic [33:0]       need;
    logic              ld_bad, st_bad, nxt_bad;
    logic [3:0]        err_pre, err;
    logic [RAW-1:0]    sv_ret;
    logic [SPW-1:0]    sv_fb;
    logic [31:0]       res, quo, rmd;
    logic              commit_ok;
    logic [SPW-1:0]    raddr, waddr, sp_new, fb_new;
    logic [FCW-1:0]    fc_new;
    logic [31:0]       wdata;
    logic              we, fwe;
    logic [32:0]       rem_sh, diff;

    assign op   = r_in.func;
    assign pops = op_pops(op);
    assign push = op_push(op);
    assign olen = op_len(op);
    assign len  = (r_plen < LEN_CAP) ? r_plen : LEN_CAP;

    // operand and address arithmetic
    assign imm_x  = {{2{r_in.imm_first[31]}}, r_in.imm_first};
    assign nl     = (op == OP_ALLOC && !r_in.imm_first[31]) ? r_in.imm_first[30:0] : '0;
    assign need   = 34'(r_sp) + 34'(push) + 34'(nl) - 34'(pops);
    assign sp_s   = $signed(34'(r_sp));
    assign idx    = $signed(34'(r_fb)) + imm_x;
    assign ld_bad = (idx < 0) || (idx >= sp_s);
    assign st_bad = (idx < 0) || (idx >= sp_s - 34'sd1);
    assign sv_ret = r_frd[FW-1:SPW];
    assign sv_fb  = r_frd[SPW-1:0];
    assign ia_x   = $signed(34'(r_ia));

    // next instruction address
    always_comb begin
        nxt = ia_x + $signed(34'(olen));
        unique case (op)
            OP_JMP:  nxt = imm_x;
            OP_JZ:   nxt = (r_b == 32'd0) ? imm_x : ia_x + $signed(34'(olen));
            OP_CALL: nxt = imm_x;
            OP_RET:  nxt = $signed(34'(sv_ret));
            default: nxt = ia_x + $signed(34'(olen));
        endcase
    end
    assign nxt_bad = (nxt < 0) || (nxt >= $signed(34'(len)));

    // error checks in priority order
    always_comb begin
        err_pre = ERR_NONE;
        if (r_ia >= len) begin
            err_pre = ERR_ADDR;
        end else if (op > OP_HALT) begin
            err_pre = ERR_UNKNOWN;
        end else if (r_sp < SPW'(pops)) begin
            err_pre = ERR_UNDER;
        end else if (need >= 34'(STACK_DEPTH)) begin
            err_pre = ERR_OVER;
        end else begin
            unique case (op)
                OP_DIV:   if (r_b == 32'd0) err_pre = ERR_DIVZ;
                OP_MOD:   if (r_b == 32'd0) err_pre = ERR_MODZ;
                OP_LOAD:  if (ld_bad) err_pre = ERR_SLOT;
                OP_PUT:   if (st_bad) err_pre = ERR_SLOT;
                OP_CALL: begin
                    if (r_fc >= FCW'(FRAME_DEPTH)) begin
                        err_pre = ERR_CALLOV;
                    end else if (32'(r_in.imm_second) > 32'(r_sp)) begin
                        err_pre = ERR_UNDER;
                    end
                end
                OP_RET: begin
                    if (r_fc == '0) begin
                        err_pre = ERR_NOFRAME;
                    end else if (r_fb == SPW'(STACK_DEPTH - 1)) begin
                        err_pre = ERR_OVER;
                    end
                end
                default: err_pre = ERR_NONE;
            endcase
        end
    end

    assign err = (err_pre != ERR_NONE) ? err_pre :
                 ((op != OP_HALT && nxt_bad) ? ERR_ADDR : ERR_NONE);
    assign commit_ok = i_cmd.commit && !r_stopped && err == ERR_NONE && op != OP_HALT;

    // signed divide results from the magnitude divider
    assign quo = (r_a[31] ^ r_b[31]) ? (32'd0 - r_dq) : r_dq;
    assign rmd = r_a[31] ? (32'd0 - r_rem[31:0]) : r_rem[31:0];

    // alu
    always_comb begin
        res = 32'd0;
        unique case (op)
            OP_PUSHI: res = r_in.imm_first;
            OP_ADD:   res = r_a + r_b;
            OP_SUB:   res = r_a - r_b;
            OP_MUL:   res = r_a * r_b;
            OP_DIV:   res = quo;
            OP_MOD:   res = rmd;
            OP_NEG:   res = 32'd0 - r_b;
            OP_EQ:    res = {31'd0, r_a == r_b};
            OP_NEQ:   res = {31'd0, r_a != r_b};
            OP_LT:    res = {31'd0, $signed(r_a) <  $signed(r_b)};
            OP_GT:    res = {31'd0, $signed(r_a) >  $signed(r_b)};
            OP_LTE:   res = {31'd0, $signed(r_a) <= $signed(r_b)};
            OP_GTE:   res = {31'd0, $signed(r_a) >= $signed(r_b)};
            OP_AND:   res = {31'd0, (r_a != 32'd0) && (r_b != 32'd0)};
            OP_OR:    res = {31'd0, (r_a != 32'd0) || (r_b != 32'd0)};
            OP_NOT:   res = {31'd0, r_b == 32'd0};
            OP_LOAD:  res = r_rd;
            OP_SCAN:  res = r_in.scan_value;
            default:  res = 32'd0;
        endcase
    end

    // new stack pointer, frame base and frame count
    always_comb begin
        sp_new = SPW'(r_sp - SPW'(pops) + SPW'(push));
        fb_new = r_fb;
        fc_new = r_fc;
        unique case (op)
            OP_RET: begin
                sp_new = SPW'(r_fb + SPW'(1));
                fb_new = sv_fb;
                fc_new = FCW'(r_fc - FCW'(1));
            end
            OP_ALLOC: sp_new = r_sp;
            OP_CALL: begin
                fb_new = SPW'(32'(r_sp) - 32'(r_in.imm_second));
                fc_new = FCW'(r_fc + FCW'(1));
            end
            default: fb_new = r_fb;
        endcase
    end

    // stack read and write port select
    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_TOP:  raddr = SPW'(r_sp - SPW'(1));
            RD_NEXT: raddr = SPW'(r_sp - SPW'(2));
            RD_SLOT: raddr = idx[SPW-1:0];
            default: raddr = r_sp;
        endcase
    end

    always_comb begin
        we    = 1'b0;
        waddr = SPW'(r_sp - SPW'(pops));
        wdata = res;
        if (i_cmd.fill_step) begin
            we    = 1'b1;
            waddr = r_sp;
            wdata = 32'd0;
        end else if (commit_ok) begin
            unique case (op)
                OP_PUT: begin
                    we    = 1'b1;
                    waddr = idx[SPW-1:0];
                    wdata = r_b;
                end
                OP_RET: begin
                    we    = 1'b1;
                    waddr = r_fb;
                    wdata = r_b;
                end
                default: we = push;
            endcase
        end
    end
    assign fwe = commit_ok && op == OP_CALL;

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd <= r_stack[raddr];
        end
        if (we) begin
            r_stack[waddr] <= wdata;
        end
        r_frd <= r_frame[FAW'(r_fc - FCW'(1))];
        if (fwe) begin
            r_frame[r_fc[FAW-1:0]] <= {RAW'(r_ia) + RAW'(olen), r_fb};
        end
    end

    // restoring divider step on magnitudes
    assign rem_sh = {r_rem[31:0], r_dq[31]};
    assign diff   = rem_sh - {1'b0, r_dd};

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp      <= '0;
            r_fb      <= '0;
            r_ia      <= '0;
            r_fc      <= '0;
            r_fill    <= '0;
            r_stopped <= 1'b0;
            r_err     <= ERR_NONE;
            r_halt    <= 32'd0;
            r_plen    <= '0;
            r_ovalid  <= 1'b0;
            r_dcnt    <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_plen <= i_cfg_data;
            end
            if (i_cmd.div_start) begin
                r_dcnt <= 6'd32;
            end else if (i_cmd.div_step) begin
                r_dcnt <= r_dcnt - 6'd1;
            end
            if (i_cmd.commit && !r_stopped) begin
                if (err != ERR_NONE) begin
                    r_stopped <= 1'b1;
                    r_err     <= err;
                    r_halt    <= 32'd0;
                end else if (op == OP_HALT) begin
                    r_stopped <= 1'b1;
                    r_err     <= ERR_NONE;
                    r_halt    <= (r_sp != '0) ? r_b : 32'd0;
                end else begin
                    r_sp   <= sp_new;
                    r_fb   <= fb_new;
                    r_fc   <= fc_new;
                    r_ia   <= nxt[AW-1:0];
                    r_fill <= (op == OP_ALLOC) ? nl[SPW-1:0] : '0;
                end
            end
            if (i_cmd.fill_step) begin
                r_sp   <= SPW'(r_sp + SPW'(1));
                r_fill <= SPW'(r_fill - SPW'(1));
            end
            // output register
            if (i_cmd.load_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_in <= i_item;
        end
        if (i_cmd.cap_b) begin
            r_b <= r_rd;
        end
        if (i_cmd.cap_a) begin
            r_a <= r_rd;
        end
        if (i_cmd.div_start) begin
            r_dq  <= r_a[31] ? (32'd0 - r_a) : r_a;
            r_dd  <= r_b[31] ? (32'd0 - r_b) : r_b;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            if (!diff[32]) begin
                r_rem <= diff;
                r_dq  <= {r_dq[30:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_dq  <= {r_dq[30:0], 1'b0};
            end
        end
        if (i_cmd.commit) begin
            r_pv   <= commit_ok && op == OP_EMIT;
            r_pval <= (commit_ok && op == OP_EMIT) ? r_b : 32'd0;
        end
        if (i_cmd.load_out) begin
            r_out.next_address <= r_ia[11:0];
            r_out.print_valid  <= r_pv;
            r_out.print_value  <= r_pval;
            r_out.halted       <= r_stopped;
            r_out.halt_value   <= r_halt;
            r_out.error_code   <= r_err;
        end
    end

    // status to the sequencer
    assign o_stat.stopped   = r_stopped;
    assign o_stat.div_go    = !r_stopped && err_pre == ERR_NONE &&
                              (op == OP_DIV || op == OP_MOD);
    assign o_stat.div_done  = (r_dcnt == 6'd0);
    assign o_stat.fill_go   = commit_ok && op == OP_ALLOC && nl != '0;
    assign o_stat.fill_done = (r_fill == '0);
    assign o_stat.out_busy  = r_ovalid && i_stall;

    assign o_valid = r_ovalid;
    assign o_item  = r_out;

endmodule
